@@ design/fsqrt_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the fixed-point Newton square root.
// No dependencies; used by the interfaces, the divider and the top level.
package fsqrt_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 8;
    localparam int STEP_W        = 5;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] num;
        logic [DATA_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DATA_W-1:0] quot;
    } t_div_rsp;

endpackage

@@ design/fsqrt_ifs.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for operand and root words.
// Depends on fsqrt_pkg for the word width.
interface fsqrt_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [fsqrt_pkg::DATA_W-1:0] operand;
    modport source(output valid, output operand, input ready);
    modport sink(input valid, input operand, output ready);
endinterface

interface fsqrt_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [fsqrt_pkg::DATA_W-1:0] root;
    modport source(output valid, output root, input ready);
    modport sink(input valid, input root, output ready);
endinterface

@@ design/fixed_point_sqrt_newton_top.sv @@
`timescale 1ns / 1ps
// Fixed-point Newton square root: sequencer around one shared serial divider.
// Negative, zero and one go from accept straight to the emit state, without the divider.
// Other operands run Newton steps, each one division on the shared divider. At FRAC_BITS=8
// the worst case is an operand of 2^30 or more (16 steps).
// One word in flight; next word accepted once the result is in the output register.
// Synchronous active-low reset clears sequencer and output valid.
module fixed_point_sqrt_newton_top #(
    parameter int FRAC_BITS = fsqrt_pkg::FRAC_BITS_DEF
) (
    input logic         i_clk,
    input logic         i_rst_n,
    fsqrt_in_if.sink    i_op,
    fsqrt_out_if.source o_res
);
    localparam int DW = fsqrt_pkg::DATA_W;
    localparam int SW = fsqrt_pkg::STEP_W;
    localparam logic [DW-1:0] ONE       = DW'(1) << FRAC_BITS;
    localparam logic [DW-1:0] SMALL_MAX = DW'(6);
    localparam logic [DW-1:0] NEG_FLAG  = '1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RECIP = 3'd1;
    localparam logic [2:0] S_SETUP = 3'd2;
    localparam logic [2:0] S_CNT   = 3'd3;
    localparam logic [2:0] S_LOOP  = 3'd4;
    localparam logic [2:0] S_NEWT  = 3'd5;
    localparam logic [2:0] S_FINAL = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    logic [2:0]    r_state, n_state;
    logic          r_inv, n_inv;
    logic [DW-1:0] r_a, n_a;
    logic [DW-1:0] r_l, n_l;
    logic [DW-1:0] r_s, n_s;
    logic [SW-1:0] r_steps, n_steps;
    logic [DW-1:0] r_res, n_res;
    logic          r_ovld, n_ovld;
    logic [DW-1:0] r_root, n_root;

    fsqrt_pkg::t_div_req div_req;
    fsqrt_pkg::t_div_rsp div_rsp;

    logic [DW-1:0] w_op;
    logic [DW-1:0] w_sum;

    assign w_op  = i_op.operand;
    assign w_sum = r_l + div_rsp.quot;

    fsqrt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state       = r_state;
        n_inv         = r_inv;
        n_a           = r_a;
        n_l           = r_l;
        n_s           = r_s;
        n_steps       = r_steps;
        n_res         = r_res;
        n_ovld        = r_ovld & ~o_res.ready;
        n_root        = r_root;
        div_req.start = 1'b0;
        div_req.num   = r_a;
        div_req.den   = r_l;
        unique case (r_state)
            S_IDLE: begin
                if (i_op.valid) begin
                    priority if (w_op[DW-1]) begin
                        n_res   = NEG_FLAG;
                        n_state = S_EMIT;
                    end else if (w_op == '0 || w_op == ONE) begin
                        n_res   = w_op;
                        n_state = S_EMIT;
                    end else if (w_op < ONE && w_op > SMALL_MAX) begin
                        n_inv         = 1'b1;
                        div_req.start = 1'b1;
                        div_req.num   = ONE;
                        div_req.den   = w_op;
                        n_state       = S_RECIP;
                    end else begin
                        n_inv   = 1'b0;
                        n_a     = w_op;
                        n_state = S_SETUP;
                    end
                end
            end
            S_RECIP: begin
                if (div_rsp.done) begin
                    n_a     = div_rsp.quot;
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_l = {1'b0, r_a[DW-1:1]} + 1'b1;
                if (!r_a[DW-1] && r_a > ONE) begin
                    n_s     = r_a;
                    n_steps = '0;
                    n_state = S_CNT;
                end else begin
                    n_steps = SW'(FRAC_BITS);
                    n_state = S_LOOP;
                end
            end
            S_CNT: begin
                if (r_s == '0) begin
                    n_state = S_LOOP;
                end else begin
                    n_s     = {2'b00, r_s[DW-1:2]};
                    n_steps = r_steps + 1'b1;
                end
            end
            S_LOOP: begin
                if (r_steps == '0) begin
                    if (r_inv) begin
                        div_req.start = 1'b1;
                        div_req.num   = ONE;
                        div_req.den   = r_l;
                        n_state       = S_FINAL;
                    end else begin
                        n_res   = r_l;
                        n_state = S_EMIT;
                    end
                end else begin
                    div_req.start = 1'b1;
                    n_state       = S_NEWT;
                end
            end
            S_NEWT: begin
                if (div_rsp.done) begin
                    n_l     = {w_sum[DW-1], w_sum[DW-1:1]};
                    n_steps = r_steps - 1'b1;
                    n_state = S_LOOP;
                end
            end
            S_FINAL: begin
                if (div_rsp.done) begin
                    n_res   = div_rsp.quot;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_ovld || o_res.ready) begin
                    n_ovld  = 1'b1;
                    n_root  = r_res;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
            r_steps <= '0;
            r_inv   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovld  <= n_ovld;
            r_steps <= n_steps;
            r_inv   <= n_inv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_l    <= n_l;
        r_s    <= n_s;
        r_res  <= n_res;
        r_root <= n_root;
    end

    assign i_op.ready  = (r_state == S_IDLE);
    assign o_res.valid = r_ovld;
    assign o_res.root  = r_root;

    a_idle_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !div_rsp.busy)
        else $error("divider busy while sequencer idle");

    a_start_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_RECIP || r_state == S_NEWT || r_state == S_FINAL))
        else $error("divider finished outside a wait state");

    a_neg_direct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op.valid && i_op.ready && i_op.operand[DW-1]) |=>
            (r_state == S_EMIT && r_res == NEG_FLAG))
        else $error("negative operand not flagged directly");

endmodule

@@ design/fsqrt_div.sv @@
`timescale 1ns / 1ps
// Bit-serial restoring divider: (num << FRAC_BITS) / den, truncated, low 32 bits.
// One quotient bit per cycle. Depends on fsqrt_pkg.
module fsqrt_div #(
    parameter int FRAC_BITS = fsqrt_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fsqrt_pkg::t_div_req i_req,
    output fsqrt_pkg::t_div_rsp o_rsp
);
    localparam int NW = fsqrt_pkg::DATA_W + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);
    localparam int DW = fsqrt_pkg::DATA_W;

    logic [NW-1:0] r_num;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_dmag;
    logic          r_dneg;
    logic [DW-1:0] r_quo;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [DW:0]   w_rem_sh;
    logic [DW+1:0] w_diff;
    logic          w_fits;

    assign w_rem_sh = {r_rem, r_num[NW-1]};
    assign w_diff   = {1'b0, w_rem_sh} - {2'b00, r_dmag};
    assign w_fits   = ~w_diff[DW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num  <= {i_req.num, {FRAC_BITS{1'b0}}};
            r_rem  <= '0;
            r_dneg <= i_req.den[DW-1];
            r_dmag <= i_req.den[DW-1] ? (~i_req.den + 1'b1) : i_req.den;
        end else if (r_busy) begin
            r_rem <= w_fits ? w_diff[DW-1:0] : w_rem_sh[DW-1:0];
            r_num <= {r_num[NW-2:0], 1'b0};
            r_quo <= {r_quo[DW-2:0], w_fits};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_dneg ? (~r_quo + 1'b1) : r_quo;

endmodule
